### sv/swfs_pkg.sv
// ----------------------------------------------------------------------------
// Wall-follow steering package
// Shared types, register indexes and fixed widths of the steering block.
// ----------------------------------------------------------------------------
package swfs_pkg;

	localparam int DIST_W = 16;
	localparam int D2_W   = 17;
	localparam int XBITS  = 8;
	localparam int NUM_W  = 44;
	localparam int QUO_W  = 24;
	localparam int CNT_W  = 5;
	localparam int TOT_W  = 36;
	localparam int DEN_W  = 29;

	localparam logic [2:0] REG_MAX_WALL  = 3'd0;
	localparam logic [2:0] REG_NEAR      = 3'd1;
	localparam logic [2:0] REG_RADIUS    = 3'd2;
	localparam logic [2:0] REG_MAX_CORR  = 3'd3;
	localparam logic [2:0] REG_MAX_PAIR  = 3'd4;
	localparam logic [2:0] REG_GAIN      = 3'd5;

	typedef struct packed {
		logic [15:0] wall_dist_limit;
		logic [15:0] near_threshold;
		logic [15:0] full_corr_radius;
		logic [15:0] max_correction;
		logic [15:0] max_pair_difference;
		logic [8:0]  motor_gain;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [NUM_W-1:0] den_sh;
		logic [CNT_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_SIDE   = 11'b000_0000_0010,
		S_CLR    = 11'b000_0000_0100,
		S_CDIV   = 11'b000_0000_1000,
		S_PAIR   = 11'b000_0001_0000,
		S_DRIFT  = 11'b000_0010_0000,
		S_DEN    = 11'b000_0100_0000,
		S_NSTART = 11'b000_1000_0000,
		S_NDIV   = 11'b001_0000_0000,
		S_SCALE  = 11'b010_0000_0000,
		S_FIN    = 11'b100_0000_0000
	} state_t;

endpackage

### sv/swfs_if.sv
// ----------------------------------------------------------------------------
// Wall-follow steering channels
// Valid/ready channels for the sonar requests and the steering results.
// ----------------------------------------------------------------------------
interface swfs_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] left_front_distance;
	logic [15:0] right_front_distance;
	logic [15:0] left_back_distance;
	logic [15:0] right_back_distance;
	logic [7:0]  base_speed;

	modport source(output valid, left_front_distance, right_front_distance,
		left_back_distance, right_back_distance, base_speed, input ready);
	modport sink(input valid, left_front_distance, right_front_distance,
		left_back_distance, right_back_distance, base_speed, output ready);
endinterface

interface swfs_out_if;
	logic              valid;
	logic              ready;
	logic [7:0]        left_speed;
	logic [7:0]        right_speed;
	logic signed [9:0] correction;

	modport source(output valid, left_speed, right_speed, correction, input ready);
	modport sink(input valid, left_speed, right_speed, correction, output ready);
endinterface

### sv/swfs_regs.sv
// ----------------------------------------------------------------------------
// Wall-follow steering registers
// APB register file holding the six steering settings.
// ----------------------------------------------------------------------------
module swfs_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output swfs_pkg::cfg_t     cfg
);

	swfs_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     idx;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wall_dist_limit     <= 16'd3072;
			cfg_q.near_threshold      <= 16'd2048;
			cfg_q.full_corr_radius    <= 16'd1280;
			cfg_q.max_correction      <= 16'd256;
			cfg_q.max_pair_difference <= 16'd768;
			cfg_q.motor_gain          <= 9'd128;
		end else if (wr_en) begin
			case (idx)
				swfs_pkg::REG_MAX_WALL: cfg_q.wall_dist_limit     <= pwdata[15:0];
				swfs_pkg::REG_NEAR:     cfg_q.near_threshold      <= pwdata[15:0];
				swfs_pkg::REG_RADIUS:   cfg_q.full_corr_radius    <= pwdata[15:0];
				swfs_pkg::REG_MAX_CORR: cfg_q.max_correction      <= pwdata[15:0];
				swfs_pkg::REG_MAX_PAIR: cfg_q.max_pair_difference <= pwdata[15:0];
				swfs_pkg::REG_GAIN:     cfg_q.motor_gain          <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			swfs_pkg::REG_MAX_WALL: prdata = {16'd0, cfg_q.wall_dist_limit};
			swfs_pkg::REG_NEAR:     prdata = {16'd0, cfg_q.near_threshold};
			swfs_pkg::REG_RADIUS:   prdata = {16'd0, cfg_q.full_corr_radius};
			swfs_pkg::REG_MAX_CORR: prdata = {16'd0, cfg_q.max_correction};
			swfs_pkg::REG_MAX_PAIR: prdata = {16'd0, cfg_q.max_pair_difference};
			swfs_pkg::REG_GAIN:     prdata = {23'd0, cfg_q.motor_gain};
			default:                prdata = 32'd0;
		endcase
	end

endmodule

### sv/swfs_div.sv
// ----------------------------------------------------------------------------
// Wall-follow steering divider
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// ----------------------------------------------------------------------------
module swfs_div (
	input  logic                clk,
	input  logic                arst_n,
	input  swfs_pkg::div_req_t  req,
	output swfs_pkg::div_rsp_t  rsp
);

	logic [swfs_pkg::NUM_W-1:0] rem_q;
	logic [swfs_pkg::NUM_W-1:0] dsh_q;
	logic [swfs_pkg::QUO_W-1:0] quo_q;
	logic [swfs_pkg::CNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic                       ge;

	// The caller pre-shifts the divisor so the first step tests the top quotient bit.
	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == swfs_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dsh_q <= req.den_sh;
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) rem_q <= rem_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[swfs_pkg::QUO_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

### sv/sonar_wall_follow_steering.sv
// ----------------------------------------------------------------------------
// Sonar wall-follow steering
// Keeps four side sonar readings and turns them into corrected wheel speeds.
// ----------------------------------------------------------------------------
// Usage: a request on in_ch carries four side sonar distances (Q8.8 inches)
// and a base speed. in_ch.ready is high only while the block is idle; one
// request is worked on at a time. Each request yields exactly one result on
// out_ch: the left and right wheel speeds and the signed Q1.8 correction.
// A small sequencer drives a shared one-bit-per-cycle divider: the clearance
// ramp takes 24 divider steps and the normalisation 9. A request passes the
// side, clearance, pair, drift, denominator, normalisation start, scale and
// final states, with a divide state where a division is needed, before the
// result register is loaded; the next request can be accepted in the cycle after.
// The result sits in an output register; while the receiver stalls, the
// next request may be accepted and worked on, and it waits in its final
// state until the previous result has been taken.
// Reset clears the stored readings to zero, loads the register defaults and
// empties the output register. Settings are to be written over the APB port
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sonar_wall_follow_steering #(
	parameter int DIST_FRAC_BITS = 8,
	parameter int SPEED_BITS     = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	swfs_in_if.sink     in_ch,
	swfs_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Smallest reading that counts, ceil(0.01 * one inch).
	localparam int TINY_I = ((1 << DIST_FRAC_BITS) + 99) / 100;
	localparam logic [15:0] TINY = 16'(TINY_I);
	localparam int SW = SPEED_BITS + 2;
	localparam logic signed [SW-1:0] SMAX = SW'((1 << SPEED_BITS) - 1);

	swfs_pkg::cfg_t     cfg;
	swfs_pkg::div_req_t div_req;
	swfs_pkg::div_rsp_t div_rsp;
	swfs_pkg::state_t   state_q;

	logic [15:0] cur_q [4];
	logic [15:0] prev_q [4];
	logic [7:0]  speed_q;
	logic [16:0] rd2_q, ld2_q;
	logic        neg_q;
	logic [23:0] clr_q;
	logic signed [swfs_pkg::TOT_W-1:0] total_q;
	logic [4:0]  weight_q;
	logic [swfs_pkg::DEN_W-1:0] den_q;
	logic        sign_q;
	logic signed [9:0] corr_q;
	logic [16:0] gs_q;
	logic [7:0]  left_q, right_q;
	logic signed [9:0] out_corr_q;
	logic [7:0]  out_left_q, out_right_q;
	logic        out_valid_q;

	logic [15:0] mc_eff;
	logic [8:0]  gain_eff;
	logic [16:0] nt2, rr2, mwd2;
	logic        in_acc, out_free;

	swfs_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	swfs_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	assign mc_eff   = (cfg.max_correction == 16'd0) ? 16'd1 : cfg.max_correction;
	assign gain_eff = (cfg.motor_gain > 9'd256) ? 9'd256 : cfg.motor_gain;
	assign nt2      = {cfg.near_threshold, 1'b0};
	assign rr2      = {cfg.full_corr_radius, 1'b0};
	assign mwd2     = {cfg.wall_dist_limit, 1'b0};

	assign in_ch.ready = (state_q == swfs_pkg::S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	// Twice the side distance: the average of both sensors near a wall, or
	// twice the single one that is, or zero when neither is.
	function automatic logic [16:0] side2(input logic [15:0] f, input logic [15:0] b,
		input logic [15:0] mwd);
		logic        uf, ub;
		logic [16:0] s;
		uf = f < mwd;
		ub = b < mwd;
		s  = (uf ? {1'b0, f} : 17'd0) + (ub ? {1'b0, b} : 17'd0);
		return (uf && ub) ? s : {s[15:0], 1'b0};
	endfunction

	// Clearance step: pick the side, then either a fixed value or a division.
	logic        use_r;
	logic [16:0] d2_sel;
	logic [32:0] clr_prod;
	always_comb begin
		use_r    = rd2_q < nt2;
		d2_sel   = use_r ? rd2_q : ld2_q;
		clr_prod = mc_eff * (nt2 - d2_sel);
	end

	// Pair terms carry weight ten against the single-sensor drift terms.
	logic signed [25:0] cd;
	logic signed [16:0] rdiff, ldiff;
	logic [16:0]        adr, adl;
	logic signed [25:0] tr, tl;
	logic               pr_ok, pl_ok;
	logic signed [swfs_pkg::TOT_W-1:0] pair_sum;
	always_comb begin
		cd    = neg_q ? -$signed({2'b00, clr_q}) : $signed({2'b00, clr_q});
		rdiff = $signed({1'b0, cur_q[1]}) - $signed({1'b0, cur_q[3]});
		ldiff = $signed({1'b0, cur_q[2]}) - $signed({1'b0, cur_q[0]});
		adr   = rdiff[16] ? 17'(-rdiff) : 17'(rdiff);
		adl   = ldiff[16] ? 17'(-ldiff) : 17'(ldiff);
		tr    = cd - ($signed(26'(rdiff)) <<< 8);
		tl    = cd - ($signed(26'(ldiff)) <<< 8);
		pr_ok = (adr < {1'b0, cfg.max_pair_difference}) && (rd2_q < mwd2);
		pl_ok = (adl < {1'b0, cfg.max_pair_difference}) && (ld2_q < mwd2);
		pair_sum = '0;
		if (pr_ok) pair_sum = pair_sum + (swfs_pkg::TOT_W'(tr) <<< 3)
			+ (swfs_pkg::TOT_W'(tr) <<< 1);
		if (pl_ok) pair_sum = pair_sum + (swfs_pkg::TOT_W'(tl) <<< 3)
			+ (swfs_pkg::TOT_W'(tl) <<< 1);
	end

	logic signed [swfs_pkg::TOT_W-1:0] drift_sum;
	logic [2:0]                        drift_cnt;
	always_comb begin
		drift_sum = total_q;
		drift_cnt = 3'd0;
		for (int i = 0; i < 4; i++) begin
			if (cur_q[i] < cfg.wall_dist_limit && prev_q[i] < cfg.wall_dist_limit) begin
				drift_sum = drift_sum + (swfs_pkg::TOT_W'($signed({1'b0, cur_q[i]})
					- $signed({1'b0, prev_q[i]})) <<< 8);
				drift_cnt = drift_cnt + 3'd1;
			end
		end
	end

	// Normalisation: a quotient of 512 or more skips the division, and the result saturates at 256.
	logic [swfs_pkg::TOT_W-1:0] tmag;
	logic [swfs_pkg::NUM_W-1:0] nnum;
	logic                       nsat;
	always_comb begin
		tmag = total_q[swfs_pkg::TOT_W-1] ? swfs_pkg::TOT_W'(-total_q)
			: swfs_pkg::TOT_W'(total_q);
		nnum = swfs_pkg::NUM_W'(tmag) << 8;
		nsat = nnum >= (swfs_pkg::NUM_W'(den_q) << 9);
	end

	logic [8:0] qcl;
	assign qcl = (div_rsp.quo[8:0] > 9'd256) ? 9'd256 : div_rsp.quo[8:0];

	// Speed reduction from the registered gain-speed product.
	logic [8:0]            cabs;
	logic [25:0]           red;
	logic signed [SW-1:0]  lv, rv;
	always_comb begin
		cabs = corr_q[9] ? 9'(-corr_q) : 9'(corr_q);
		red  = gs_q * cabs;
		lv   = $signed(SW'({2'b00, speed_q}));
		rv   = lv;
		if (corr_q > 10'sd0) lv = lv - $signed(SW'(red[25:16]));
		else if (corr_q < 10'sd0) rv = rv - $signed(SW'(red[25:16]));
		if (lv < 0) lv = '0;
		if (lv > SMAX) lv = SMAX;
		if (rv < 0) rv = '0;
		if (rv > SMAX) rv = SMAX;
	end

	always_comb begin
		div_req = '0;
		if (state_q == swfs_pkg::S_CLR && d2_sel < nt2 && d2_sel >= rr2) begin
			div_req.start  = 1'b1;
			div_req.num    = swfs_pkg::NUM_W'(clr_prod) << 8;
			div_req.den_sh = swfs_pkg::NUM_W'(nt2 - rr2) << 23;
			div_req.steps  = swfs_pkg::CNT_W'(24);
		end else if (state_q == swfs_pkg::S_NSTART && weight_q != 5'd0 && !nsat) begin
			div_req.start  = 1'b1;
			div_req.num    = nnum;
			div_req.den_sh = swfs_pkg::NUM_W'(den_q) << 8;
			div_req.steps  = swfs_pkg::CNT_W'(9);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swfs_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				cur_q[i]  <= '0;
				prev_q[i] <= '0;
			end
		end else begin
			// A new result is loaded as the old one leaves or once the register is empty.
			if (state_q == swfs_pkg::S_FIN && out_free) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				swfs_pkg::S_IDLE: begin
					if (in_acc) begin
						if (in_ch.left_front_distance >= TINY) begin
							prev_q[0] <= cur_q[0];
							cur_q[0]  <= in_ch.left_front_distance;
						end
						if (in_ch.right_front_distance >= TINY) begin
							prev_q[1] <= cur_q[1];
							cur_q[1]  <= in_ch.right_front_distance;
						end
						if (in_ch.left_back_distance >= TINY) begin
							prev_q[2] <= cur_q[2];
							cur_q[2]  <= in_ch.left_back_distance;
						end
						if (in_ch.right_back_distance >= TINY) begin
							prev_q[3] <= cur_q[3];
							cur_q[3]  <= in_ch.right_back_distance;
						end
						state_q <= swfs_pkg::S_SIDE;
					end
				end
				swfs_pkg::S_SIDE: state_q <= swfs_pkg::S_CLR;
				swfs_pkg::S_CLR: begin
					if (div_req.start) state_q <= swfs_pkg::S_CDIV;
					else state_q <= swfs_pkg::S_PAIR;
				end
				swfs_pkg::S_CDIV: if (div_rsp.done) state_q <= swfs_pkg::S_PAIR;
				swfs_pkg::S_PAIR: state_q <= swfs_pkg::S_DRIFT;
				swfs_pkg::S_DRIFT: state_q <= swfs_pkg::S_DEN;
				swfs_pkg::S_DEN: state_q <= swfs_pkg::S_NSTART;
				swfs_pkg::S_NSTART: begin
					if (div_req.start) state_q <= swfs_pkg::S_NDIV;
					else state_q <= swfs_pkg::S_SCALE;
				end
				swfs_pkg::S_NDIV: if (div_rsp.done) state_q <= swfs_pkg::S_SCALE;
				swfs_pkg::S_SCALE: state_q <= swfs_pkg::S_FIN;
				swfs_pkg::S_FIN: begin
					if (out_free) state_q <= swfs_pkg::S_IDLE;
				end
				default: state_q <= swfs_pkg::S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			swfs_pkg::S_IDLE: if (in_acc) speed_q <= in_ch.base_speed;
			swfs_pkg::S_SIDE: begin
				rd2_q <= side2(cur_q[1], cur_q[3], cfg.wall_dist_limit);
				ld2_q <= side2(cur_q[0], cur_q[2], cfg.wall_dist_limit);
			end
			swfs_pkg::S_CLR: begin
				neg_q <= !use_r;
				if (d2_sel >= nt2) clr_q <= '0;
				else if (d2_sel < rr2) clr_q <= {mc_eff, 8'd0};
			end
			swfs_pkg::S_CDIV: if (div_rsp.done) clr_q <= div_rsp.quo;
			swfs_pkg::S_PAIR: begin
				total_q  <= pair_sum;
				weight_q <= (pr_ok ? 5'd10 : 5'd0) + (pl_ok ? 5'd10 : 5'd0);
			end
			swfs_pkg::S_DRIFT: begin
				total_q  <= drift_sum;
				weight_q <= weight_q + {2'b00, drift_cnt};
			end
			swfs_pkg::S_DEN: begin
				den_q  <= swfs_pkg::DEN_W'({16'd0, weight_q} * {5'd0, mc_eff}) << 8;
				sign_q <= total_q[swfs_pkg::TOT_W-1];
				gs_q   <= gain_eff * speed_q;
			end
			swfs_pkg::S_NSTART: begin
				if (weight_q == 5'd0) corr_q <= '0;
				else if (nsat) corr_q <= sign_q ? -10'sd256 : 10'sd256;
			end
			swfs_pkg::S_NDIV: begin
				if (div_rsp.done)
					corr_q <= sign_q ? -$signed({1'b0, qcl}) : $signed({1'b0, qcl});
			end
			swfs_pkg::S_SCALE: begin
				left_q  <= lv[7:0];
				right_q <= rv[7:0];
			end
			swfs_pkg::S_FIN: begin
				if (out_free) begin
					out_left_q  <= left_q;
					out_right_q <= right_q;
					out_corr_q  <= corr_q;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.left_speed  = out_left_q;
	assign out_ch.right_speed = out_right_q;
	assign out_ch.correction  = out_corr_q;

	a_corr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.correction <= 10'sd256 && out_ch.correction >= -10'sd256))
		else $error("correction out of range");

	a_left_slows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.correction > 10'sd0) |-> out_ch.left_speed <= out_ch.right_speed)
		else $error("positive correction did not slow the left wheel");

	a_no_corr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.correction == 10'sd0) |-> out_ch.left_speed == out_ch.right_speed)
		else $error("zero correction changed a wheel speed");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> (state_q == swfs_pkg::S_CDIV || state_q == swfs_pkg::S_NDIV))
		else $error("divider busy outside a divide state");

endmodule

### bench/sonar_wall_follow_steering_tb.sv
// ----------------------------------------------------------------------------
// Sonar wall-follow steering testbench
// Drives sonar requests and register writes into the steering block, predicts
// each steering result from its own copy of the readings and the settings,
// and checks every result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sonar_wall_follow_steering_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] left_speed;
		logic [7:0] right_speed;
		logic [9:0] correction;
	} steer_t;

	int unsigned error_count = 0;

	// Reports one mismatch on a line of its own and counts it.
	task automatic report_mismatch(input string what);
		error_count++;
		$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	// The scoreboard keeps its own copy of the settings and of the readings
	// and holds the steering results still owed by the block.
	class steer_scoreboard;
		logic [15:0] wall_lim, near_thr, radius, corr_max, pair_max;
		logic [8:0]  gain;
		logic [15:0] cur[4];
		logic [15:0] prev[4];
		steer_t      owed[$];

		function void clear();
			wall_lim = 3072; near_thr = 2048; radius = 1280;
			corr_max = 256; pair_max = 768; gain = 128;
			foreach (cur[i]) begin
				cur[i] = 0;
				prev[i] = 0;
			end
			owed.delete();
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				swfs_pkg::REG_MAX_WALL: wall_lim = val[15:0];
				swfs_pkg::REG_NEAR:     near_thr = val[15:0];
				swfs_pkg::REG_RADIUS:   radius = val[15:0];
				swfs_pkg::REG_MAX_CORR: corr_max = val[15:0];
				swfs_pkg::REG_MAX_PAIR: pair_max = val[15:0];
				swfs_pkg::REG_GAIN:     gain = val[8:0];
				default: ;
			endcase
		endfunction

		// Twice the side distance: a lone near sensor counts double.
		function longint side2(int f, int b);
			bit uf, ub;
			longint s;
			uf = cur[f] < wall_lim;
			ub = cur[b] < wall_lim;
			s = (uf ? cur[f] : 0) + (ub ? cur[b] : 0);
			return (uf && ub) ? s : 2 * s;
		endfunction

		function longint clear_term(longint d2, longint mc);
			longint nt2, rr2;
			nt2 = 2 * longint'(near_thr);
			rr2 = 2 * longint'(radius);
			if (d2 >= nt2) return 0;
			if (d2 < rr2) return mc <<< 8;
			return ((mc * (nt2 - d2)) <<< 8) / (nt2 - rr2);
		endfunction

		// Notes an accepted sonar request and predicts its result.
		function void note_request(logic [15:0] d[4], logic [7:0] spd);
			longint mc, g, total, weight, rd2, ld2, cd, rdiff, ldiff, c, l, r, dd;
			steer_t e;
			mc = corr_max ? corr_max : 1;
			g = gain > 256 ? 256 : gain;
			total = 0; weight = 0; c = 0;
			for (int i = 0; i < 4; i++)
				if (d[i] >= 3) begin
					prev[i] = cur[i];
					cur[i] = d[i];
				end
			rd2 = side2(1, 3);
			ld2 = side2(0, 2);
			if (rd2 < 2 * longint'(near_thr)) cd = clear_term(rd2, mc);
			else cd = -clear_term(ld2, mc);
			rdiff = longint'(cur[1]) - longint'(cur[3]);
			ldiff = longint'(cur[2]) - longint'(cur[0]);
			if ((rdiff < 0 ? -rdiff : rdiff) < pair_max && rd2 < 2 * longint'(wall_lim)) begin
				total += 10 * (cd - rdiff * 256);
				weight += 10;
			end
			if ((ldiff < 0 ? -ldiff : ldiff) < pair_max && ld2 < 2 * longint'(wall_lim)) begin
				total += 10 * (cd - ldiff * 256);
				weight += 10;
			end
			for (int i = 0; i < 4; i++)
				if (cur[i] < wall_lim && prev[i] < wall_lim) begin
					dd = longint'(cur[i]) - longint'(prev[i]);
					total += dd * 256;
					weight += 1;
				end
			if (weight > 0) begin
				// SystemVerilog division truncates toward zero.
				c = (total * 256) / ((weight * mc) <<< 8);
				if (c > 256) c = 256;
				else if (c < -256) c = -256;
			end
			l = spd;
			r = spd;
			if (c > 0) l -= (g * spd * c) >> 16;
			else if (c < 0) r -= (g * spd * (-c)) >> 16;
			if (l < 0) l = 0;
			if (r < 0) r = 0;
			if (l > 255) l = 255;
			if (r > 255) r = 255;
			e.left_speed = l[7:0];
			e.right_speed = r[7:0];
			e.correction = c[9:0];
			owed.push_back(e);
		endfunction

		task check_result(logic [7:0] ls, logic [7:0] rs, logic [9:0] cr);
			steer_t e;
			if (owed.size() == 0) begin
				report_mismatch("steering result with no request outstanding");
				return;
			end
			e = owed.pop_front();
			if (ls !== e.left_speed)
				report_mismatch($sformatf("left_speed %0d, want %0d", ls, e.left_speed));
			if (rs !== e.right_speed)
				report_mismatch($sformatf("right_speed %0d, want %0d", rs, e.right_speed));
			if (cr !== e.correction)
				report_mismatch($sformatf("correction %0d, want %0d",
					$signed(cr), $signed(e.correction)));
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [4:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic        pready;

	swfs_in_if  in_ch();
	swfs_out_if out_ch();

	sonar_wall_follow_steering i_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	steer_scoreboard sb = new();
	int unsigned     idle_cycles = 0;
	bit              stall_on = 0;
	int unsigned     stall_mode = 0;

	initial begin
		in_ch.valid = 0;
		in_ch.left_front_distance = 0;
		in_ch.right_front_distance = 0;
		in_ch.left_back_distance = 0;
		in_ch.right_back_distance = 0;
		in_ch.base_speed = 0;
		out_ch.ready = 0;
		sb.clear();
	end

	// Every accepted request is noted and every accepted result is checked
	// at the rising edge, so both see the values set up at the falling edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_request('{in_ch.left_front_distance, in_ch.right_front_distance,
					in_ch.left_back_distance, in_ch.right_back_distance},
					in_ch.base_speed);
			if (out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.left_speed, out_ch.right_speed, out_ch.correction);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles > 2000) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// The receiver stalls on its own pattern: phases of always ready, random
	// stalls on about a third of the cycles, and stalls of varying length.
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0: out_ch.ready <= 1;
			1: out_ch.ready <= ($urandom_range(0, 2) != 0);
			default: begin
				if ($urandom_range(0, 7) == 0) stall_on = !stall_on;
				out_ch.ready <= !stall_on;
			end
		endcase
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// Waits until every owed result has come, plus the block's latency.
	task automatic drain();
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Offers one request at the falling edge and holds it until accepted.
	// The valid line stays high across back-to-back requests; otherwise it
	// drops low before the next request is offered.
	task automatic send_request(input logic [15:0] lf, rf, lb, rb, input logic [7:0] spd,
		input bit keep);
		in_ch.valid <= 1;
		in_ch.left_front_distance <= lf;
		in_ch.right_front_distance <= rf;
		in_ch.left_back_distance <= lb;
		in_ch.right_back_distance <= rb;
		in_ch.base_speed <= spd;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
		if (!keep) begin
			in_ch.valid <= 0;
			@(negedge clk);
		end
	endtask

	// Distances mostly near the wall band, with tiny readings and extremes.
	function automatic logic [15:0] pick_dist(logic [15:0] wall);
		int unsigned k;
		k = $urandom_range(0, 19);
		if (k == 0) return 16'($urandom_range(0, 3));
		if (k == 1) return 16'($urandom());
		if (k == 2) return 16'hFFFF;
		if (k < 6) return 16'($urandom_range(0, 6000));
		return 16'($urandom_range(0, wall + 200));
	endfunction

	task automatic random_phase(input int n);
		int left, gap;
		logic [15:0] base, lf, rf, lb, rb;
		left = n;
		while (left > 0) begin
			int burst;
			burst = $urandom_range(1, 12);
			while (burst > 0 && left > 0) begin
				base = 16'($urandom_range(256, 3000));
				if ($urandom_range(0, 3) != 0) begin
					// Wall-follow like readings: a pair close together.
					lf = 16'(base + $urandom_range(0, 600) - 300);
					lb = 16'(base + $urandom_range(0, 600) - 300);
					rf = pick_dist(3072);
					rb = 16'(rf + $urandom_range(0, 600) - 300);
				end else begin
					lf = pick_dist(3072); rf = pick_dist(3072);
					lb = pick_dist(3072); rb = pick_dist(3072);
				end
				send_request(lf, rf, lb, rb, 8'($urandom()), burst > 1 && left > 1);
				burst--;
				left--;
			end
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
			repeat (gap) @(negedge clk);
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed: defaults, tiny readings, extremes, lone sensors, no terms.
		send_request(0, 0, 0, 0, 0, 0);
		send_request(2, 1, 2, 1, 255, 0);
		send_request(3, 3, 3, 3, 255, 0);
		send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 255, 0);
		send_request(1000, 16'hFFFF, 1000, 16'hFFFF, 200, 0);
		send_request(16'hFFFF, 1000, 16'hFFFF, 1000, 200, 0);
		send_request(500, 16'hFFFF, 16'hFFFF, 16'hFFFF, 128, 0);
		send_request(1400, 1400, 1500, 1300, 255, 0);
		send_request(2000, 2600, 2100, 2500, 100, 0);
		send_request(2000, 600, 2100, 700, 100, 0);
		send_request(600, 2600, 700, 2500, 255, 0);
		send_request(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 8'h55, 0);
		send_request(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 8'hAA, 0);
		drain();

		// Extreme settings: zero max correction, gain above one, open limits.
		reg_write(swfs_pkg::REG_MAX_CORR, 0);
		reg_write(swfs_pkg::REG_GAIN, 9'h1FF);
		reg_write(swfs_pkg::REG_MAX_WALL, 16'hFFFF);
		reg_write(swfs_pkg::REG_MAX_PAIR, 16'hFFFF);
		reg_write(swfs_pkg::REG_NEAR, 16'hFFFF);
		reg_write(swfs_pkg::REG_RADIUS, 0);
		reg_write(3'd7, 32'h1234);
		send_request(100, 60000, 200, 65000, 255, 0);
		send_request(65000, 100, 60000, 50, 255, 0);
		send_request(30000, 30000, 30000, 30000, 255, 0);
		random_phase(100);
		drain();

		// Tight settings: zero limits, zero gain and the largest max correction.
		reg_write(swfs_pkg::REG_MAX_WALL, 0);
		reg_write(swfs_pkg::REG_MAX_PAIR, 0);
		reg_write(swfs_pkg::REG_GAIN, 0);
		reg_write(swfs_pkg::REG_MAX_CORR, 16'hFFFF);
		random_phase(50);
		drain();

		// Back to defaults but for a gain of 256, then random settings per phase.
		reg_write(swfs_pkg::REG_MAX_WALL, 3072);
		reg_write(swfs_pkg::REG_NEAR, 2048);
		reg_write(swfs_pkg::REG_RADIUS, 1280);
		reg_write(swfs_pkg::REG_MAX_CORR, 256);
		reg_write(swfs_pkg::REG_MAX_PAIR, 768);
		reg_write(swfs_pkg::REG_GAIN, 256);
		random_phase(150);
		drain();
		for (int p = 0; p < 6; p++) begin
			int unsigned nt;
			nt = $urandom_range(300, 4000);
			reg_write(swfs_pkg::REG_MAX_WALL, $urandom_range(1000, 5000));
			reg_write(swfs_pkg::REG_NEAR, nt);
			reg_write(swfs_pkg::REG_RADIUS, $urandom_range(0, nt - 1));
			reg_write(swfs_pkg::REG_MAX_CORR, $urandom_range(1, 2000));
			reg_write(swfs_pkg::REG_MAX_PAIR, $urandom_range(100, 2000));
			reg_write(swfs_pkg::REG_GAIN, $urandom_range(0, 300));
			random_phase(50);
			drain();
		end

		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
